[sv/mel_pkg.sv]
// ----------------------------------------------------------------------------
// mel_pkg
// operation codes and record layout for the memory error log
// ----------------------------------------------------------------------------
`default_nettype none

package mel_pkg;

	// operation codes
	localparam logic [1:0] OP_CHECK  = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_CLEAR  = 2'd2;

	localparam int CHIP_W = 5;
	localparam int ADDR_W = 32;
	localparam int BYTE_W = 8;

	// one logged mismatch
	typedef struct packed {
		logic [CHIP_W-1:0] chip;
		logic [ADDR_W-1:0] address;
		logic [BYTE_W-1:0] read_val;
		logic [BYTE_W-1:0] written_val;
	} log_rec_t;

	localparam int REC_W = $bits(log_rec_t);

endpackage

`default_nettype wire

[sv/mel_ram.sv]
// ----------------------------------------------------------------------------
// mel_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module mel_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

[sv/memory_error_logging_fifo.sv]
// ----------------------------------------------------------------------------
// memory_error_logging_fifo
// bounded ring log of memory-test mismatches with check, remove and clear
// ----------------------------------------------------------------------------
// the result is registered: done strobes in the cycle after start is taken
// throughput: one word per cycle, busy stays low; the ring ram has one
//   write and one registered read port, enough for one push or pop a cycle
// the result is shown for exactly one cycle and cannot be stalled
// reset (arst_n low, asynchronous) empties the ring: head, tail and count
//   return to zero; ring contents are not cleared and are never read unwritten
// ----------------------------------------------------------------------------
`default_nettype none

module memory_error_logging_fifo #(
	parameter int QUEUE_DEPTH = 64
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// command side
	input  wire logic                             start,
	output      logic                             busy,
	input  wire logic [1:0]                       operation,
	input  wire logic [mel_pkg::CHIP_W-1:0]       chip_id,
	input  wire logic [mel_pkg::ADDR_W-1:0]       byte_address,
	input  wire logic [mel_pkg::BYTE_W-1:0]       read_byte,
	input  wire logic [mel_pkg::BYTE_W-1:0]       written_byte,
	// result side
	output      logic                             done,
	output      logic                             error_logged,
	output      logic                             error_dropped,
	output      logic                             record_valid,
	output      logic [mel_pkg::CHIP_W-1:0]       record_chip,
	output      logic [mel_pkg::ADDR_W-1:0]       record_address,
	output      logic [mel_pkg::BYTE_W-1:0]       record_read,
	output      logic [mel_pkg::BYTE_W-1:0]       record_written,
	output      logic [$clog2(QUEUE_DEPTH+1)-1:0] entry_total
);

	import mel_pkg::*;

	localparam int IDX_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

	// ring pointers and fill count
	logic [IDX_W-1:0] head_q;
	logic [IDX_W-1:0] tail_q;
	logic [CNT_W-1:0] count_q;

	// decode of the word being taken
	logic     accept;
	logic     mismatch;
	logic     do_push;
	logic     do_drop;
	logic     do_pop;
	logic     do_clear;
	log_rec_t wr_rec;
	log_rec_t rd_rec;

	// result stage
	logic done_s1;
	logic logged_s1;
	logic dropped_s1;
	logic popped_s1;

	// never stalls: every cycle can take a word
	assign busy   = 1'b0;
	assign accept = start && !busy;

	assign mismatch = (read_byte ^ written_byte) != '0;

	always_comb begin
		do_push  = 1'b0;
		do_drop  = 1'b0;
		do_pop   = 1'b0;
		do_clear = 1'b0;
		case (operation)
			OP_CHECK: begin
				// full ring drops the record and leaves state alone
				do_push = accept && mismatch && (count_q < FULL_CNT);
				do_drop = accept && mismatch && (count_q >= FULL_CNT);
			end
			OP_REMOVE: begin
				// remove on an empty ring shows nothing
				do_pop = accept && (count_q != '0);
			end
			OP_CLEAR: begin
				do_clear = accept;
			end
			default: begin
				// unused code: no state change
			end
		endcase
	end

	assign wr_rec = '{chip: chip_id, address: byte_address,
		read_val: read_byte, written_val: written_byte};

	// ring store, read data lands in the result cycle
	mel_ram #(
		.WIDTH(REC_W),
		.DEPTH(QUEUE_DEPTH)
	) u_ring (
		.clk  (clk),
		.we   (do_push),
		.waddr(tail_q),
		.wdata(wr_rec),
		.re   (do_pop),
		.raddr(head_q),
		.rdata(rd_rec)
	);

	// pointer and count update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else if (do_clear) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else if (do_push) begin
			// wrap at the last slot, depth need not be a power of two
			tail_q  <= (tail_q == LAST_IDX) ? '0 : tail_q + 1'b1;
			count_q <= count_q + 1'b1;
		end else if (do_pop) begin
			head_q  <= (head_q == LAST_IDX) ? '0 : head_q + 1'b1;
			count_q <= count_q - 1'b1;
		end
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s1 <= 1'b0;
		end else begin
			done_s1 <= accept;
		end
	end

	// result flags, payload only
	always_ff @(posedge clk) begin
		if (accept) begin
			logged_s1  <= do_push;
			dropped_s1 <= do_drop;
			popped_s1  <= do_pop;
		end
	end

	assign done          = done_s1;
	assign error_logged  = logged_s1;
	assign error_dropped = dropped_s1;
	assign record_valid  = popped_s1;

	// record fields read zero unless a record was popped
	assign record_chip    = popped_s1 ? rd_rec.chip        : '0;
	assign record_address = popped_s1 ? rd_rec.address     : '0;
	assign record_read    = popped_s1 ? rd_rec.read_val    : '0;
	assign record_written = popped_s1 ? rd_rec.written_val : '0;

	// count already holds the value after the item in the result cycle
	assign entry_total = count_q;

	// count never passes the ring depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("entry count above ring depth");

	// at most one outcome flag per result
	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		done_s1 |-> $onehot0({logged_s1, dropped_s1, popped_s1}))
		else $error("more than one outcome flag");

	// a drop happens only with a full ring and leaves the count unchanged
	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		do_drop |=> (count_q == FULL_CNT) && $stable(count_q))
		else $error("drop without full ring");

	// a pop never empties below zero
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		do_pop |-> count_q != '0)
		else $error("pop from empty ring");

endmodule

`default_nettype wire

[test/memory_error_logging_fifo_tb.sv]
// ----------------------------------------------------------------------------
// memory_error_logging_fifo_tb
// self-checking bench for the memory error log: directed corner words, then
// random fill, drain and mixed bursts under several idle phases, each result
// compared field by field against a ring model kept in the bench
// ----------------------------------------------------------------------------
`default_nettype none

module memory_error_logging_fifo_tb;

	import mel_pkg::*;

	localparam int RING_DEPTH = 64;
	localparam int TOTAL_W = $clog2(RING_DEPTH + 1);
	localparam int PHASE_WORDS = 420;
	localparam int SETTLE_CYCLES = 6;

	// code three is not used by the block, it must leave the log alone
	localparam logic [1:0] OP_UNUSED = 2'd3;

	// one command word as driven, plus the sender gap odds ahead of it
	typedef struct {
		logic [1:0]        op;
		logic [CHIP_W-1:0] chip;
		logic [ADDR_W-1:0] addr;
		logic [BYTE_W-1:0] rd;
		logic [BYTE_W-1:0] wr;
		int                idle_pct;
	} scrub_cmd_t;

	// what the block should show for one word
	typedef struct {
		logic               logged;
		logic               dropped;
		logic               popped;
		log_rec_t           rec;
		logic [TOTAL_W-1:0] total;
	} log_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic               start = 1'b0;
	logic [1:0]         operation = OP_CHECK;
	logic [CHIP_W-1:0]  chip_id = '0;
	logic [ADDR_W-1:0]  byte_address = '0;
	logic [BYTE_W-1:0]  read_byte = '0;
	logic [BYTE_W-1:0]  written_byte = '0;

	logic               busy;
	logic               done;
	logic               error_logged;
	logic               error_dropped;
	logic               record_valid;
	logic [CHIP_W-1:0]  record_chip;
	logic [ADDR_W-1:0]  record_address;
	logic [BYTE_W-1:0]  record_read;
	logic [BYTE_W-1:0]  record_written;
	logic [TOTAL_W-1:0] entry_total;

	memory_error_logging_fifo #(
		.QUEUE_DEPTH(RING_DEPTH)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.operation(operation),
		.chip_id(chip_id),
		.byte_address(byte_address),
		.read_byte(read_byte),
		.written_byte(written_byte),
		.done(done),
		.error_logged(error_logged),
		.error_dropped(error_dropped),
		.record_valid(record_valid),
		.record_chip(record_chip),
		.record_address(record_address),
		.record_read(record_read),
		.record_written(record_written),
		.entry_total(entry_total)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// bench copy of the error ring
	// ------------------------------------------------------------------------
	log_rec_t        shadow_ring [RING_DEPTH];
	int unsigned     shadow_head = 0;
	int unsigned     shadow_tail = 0;
	int unsigned     shadow_count = 0;

	// what the run went through, for the closing summary
	int n_logged = 0;
	int n_dropped = 0;
	int n_popped = 0;
	int n_empty_pops = 0;
	int n_clears = 0;
	int n_matches = 0;
	int n_unused = 0;

	// apply one accepted word to the shadow ring and return the due result
	function automatic log_result_t log_model_apply(scrub_cmd_t cmd);
		log_result_t res;
		res = '{logged: 1'b0, dropped: 1'b0, popped: 1'b0, rec: '0, total: '0};
		case (cmd.op)
			OP_CHECK: begin
				if ((cmd.rd ^ cmd.wr) == '0) begin
					// bytes agree: nothing to log
					n_matches++;
				end else if (shadow_count < RING_DEPTH) begin
					shadow_ring[shadow_tail] = '{chip: cmd.chip, address: cmd.addr,
						read_val: cmd.rd, written_val: cmd.wr};
					shadow_tail = (shadow_tail + 1) % RING_DEPTH;
					shadow_count++;
					res.logged = 1'b1;
					n_logged++;
				end else begin
					// ring full: the mismatch is lost but flagged
					res.dropped = 1'b1;
					n_dropped++;
				end
			end
			OP_REMOVE: begin
				if (shadow_count > 0) begin
					res.popped = 1'b1;
					res.rec = shadow_ring[shadow_head];
					shadow_head = (shadow_head + 1) % RING_DEPTH;
					shadow_count--;
					n_popped++;
				end else begin
					n_empty_pops++;
				end
			end
			OP_CLEAR: begin
				shadow_head = 0;
				shadow_tail = 0;
				shadow_count = 0;
				n_clears++;
			end
			default: begin
				n_unused++;
			end
		endcase
		res.total = TOTAL_W'(shadow_count);
		return res;
	endfunction

	// ------------------------------------------------------------------------
	// driver: feeds words from the backlog, predicts each one as it is taken
	// ------------------------------------------------------------------------
	scrub_cmd_t  cmd_backlog [$];
	log_result_t log_results_due [$];
	scrub_cmd_t  on_bus;
	int          words_planned = 0;
	int          words_taken = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			// a word is taken at this edge when start is up and busy is down
			if (start && !busy) begin
				log_results_due.push_back(log_model_apply(on_bus));
				words_taken++;
			end
			// only change the bus when nothing is left hanging on it
			if (!start || !busy) begin
				if (cmd_backlog.size() != 0 &&
						$urandom_range(99) >= cmd_backlog[0].idle_pct) begin
					on_bus = cmd_backlog.pop_front();
					start <= 1'b1;
					operation <= on_bus.op;
					chip_id <= on_bus.chip;
					byte_address <= on_bus.addr;
					read_byte <= on_bus.rd;
					written_byte <= on_bus.wr;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// monitor: every done strobe is checked against the oldest prediction
	// ------------------------------------------------------------------------
	int mismatches = 0;

	task automatic flag_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		mismatches++;
		$display("MISMATCH at %0t: %s got %0h want %0h", $realtime, what, got, want);
	endtask

	always @(posedge clk) begin
		log_result_t due;
		if (arst_n && done) begin
			if (log_results_due.size() == 0) begin
				flag_mismatch("result with nothing due", 32'd1, 32'd0);
			end else begin
				due = log_results_due.pop_front();
				if (error_logged !== due.logged)
					flag_mismatch("error_logged", 32'(error_logged), 32'(due.logged));
				if (error_dropped !== due.dropped)
					flag_mismatch("error_dropped", 32'(error_dropped), 32'(due.dropped));
				if (record_valid !== due.popped)
					flag_mismatch("record_valid", 32'(record_valid), 32'(due.popped));
				if (record_chip !== due.rec.chip)
					flag_mismatch("record_chip", 32'(record_chip), 32'(due.rec.chip));
				if (record_address !== due.rec.address)
					flag_mismatch("record_address", record_address, due.rec.address);
				if (record_read !== due.rec.read_val)
					flag_mismatch("record_read", 32'(record_read), 32'(due.rec.read_val));
				if (record_written !== due.rec.written_val)
					flag_mismatch("record_written", 32'(record_written),
						32'(due.rec.written_val));
				if (entry_total !== due.total)
					flag_mismatch("entry_total", 32'(entry_total), 32'(due.total));
			end
		end
	end

	// ------------------------------------------------------------------------
	// stimulus building
	// ------------------------------------------------------------------------
	task automatic queue_word(input logic [1:0] op, input logic [CHIP_W-1:0] chip,
			input logic [ADDR_W-1:0] addr, input logic [BYTE_W-1:0] rd,
			input logic [BYTE_W-1:0] wr, input int idle_pct);
		cmd_backlog.push_back('{op: op, chip: chip, addr: addr, rd: rd, wr: wr,
			idle_pct: idle_pct});
		words_planned++;
	endtask

	// scrub patterns are mostly all zeros or all ones, now and then anything
	function automatic logic [BYTE_W-1:0] pick_pattern();
		int roll;
		roll = $urandom_range(99);
		if (roll < 40)
			return '0;
		else if (roll < 80)
			return '1;
		return BYTE_W'($urandom);
	endfunction

	// a random check word; miss_pct sets how often the read-back disagrees
	task automatic queue_check(input int miss_pct, input int idle_pct);
		logic [BYTE_W-1:0] wr;
		logic [BYTE_W-1:0] rd;
		wr = pick_pattern();
		if ($urandom_range(99) >= miss_pct)
			rd = wr;
		else if ($urandom_range(1))
			rd = wr ^ (BYTE_W'(1) << $urandom_range(BYTE_W - 1)); // single stuck bit
		else
			rd = BYTE_W'($urandom) | ((wr ^ 8'h01) & 8'h00) ^ (wr == 8'h00 ? 8'h80 : 8'h00);
		if (rd == wr && $urandom_range(99) < miss_pct)
			rd = ~wr;
		queue_word(OP_CHECK, CHIP_W'($urandom), $urandom, rd, wr, idle_pct);
	endtask

	// a random stretch of scrub traffic under one idle setting
	task automatic queue_phase(input int idle_pct);
		int n;
		int roll;
		int stop_at;
		stop_at = words_planned + PHASE_WORDS;
		while (words_planned < stop_at) begin
			roll = $urandom_range(99);
			if (roll < 30) begin
				// fill run, long enough to hit a full ring now and then
				n = $urandom_range(1, RING_DEPTH + 16);
				repeat (n) queue_check(85, idle_pct);
			end else if (roll < 55) begin
				// drain run with a little check noise
				n = $urandom_range(1, RING_DEPTH + 16);
				repeat (n) begin
					if ($urandom_range(99) < 5)
						queue_check(50, idle_pct);
					else
						queue_word(OP_REMOVE, CHIP_W'($urandom), $urandom,
							BYTE_W'($urandom), BYTE_W'($urandom), idle_pct);
				end
			end else if (roll < 92) begin
				// interleaved checks and removes
				n = $urandom_range(1, 20);
				repeat (n) begin
					if ($urandom_range(1))
						queue_check(60, idle_pct);
					else
						queue_word(OP_REMOVE, CHIP_W'($urandom), $urandom,
							BYTE_W'($urandom), BYTE_W'($urandom), idle_pct);
				end
			end else if (roll < 97) begin
				queue_word(OP_CLEAR, CHIP_W'($urandom), $urandom,
					BYTE_W'($urandom), BYTE_W'($urandom), idle_pct);
			end else begin
				queue_word(OP_UNUSED, CHIP_W'($urandom), $urandom,
					BYTE_W'($urandom), BYTE_W'($urandom), idle_pct);
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------------
	initial begin
		// directed corners, back to back
		queue_word(OP_REMOVE, '0, '0, '0, '0, 0);                 // pop from empty ring
		queue_word(OP_CHECK, '0, '0, 8'h00, 8'h00, 0);           // match on zeros
		queue_word(OP_CHECK, '1, '1, 8'hFF, 8'hFF, 0);           // match on ones
		queue_word(OP_UNUSED, '0, '0, '0, '0, 0);                // unused code, empty ring
		queue_word(OP_CHECK, '1, '1, 8'h00, 8'hFF, 0);           // all-ones chip and address
		queue_word(OP_CHECK, '0, '0, 8'hFF, 8'h00, 0);           // all-zeros chip and address
		queue_word(OP_CHECK, 5'd21, 32'hAAAA_AAAA, 8'h55, 8'h00, 0);
		queue_word(OP_CHECK, 5'd10, 32'h5555_5555, 8'hA5, 8'hA5, 0);
		queue_word(OP_UNUSED, '1, '1, '1, '1, 0);                // unused code, ring holds data
		queue_word(OP_REMOVE, '1, '1, '1, '1, 0);
		queue_word(OP_REMOVE, '0, '0, '0, '0, 0);
		queue_word(OP_REMOVE, '0, '0, '0, '0, 0);
		queue_word(OP_REMOVE, '0, '0, '0, '0, 0);                // empty again
		queue_word(OP_CHECK, 5'd1, 32'h0000_0001, 8'hFE, 8'hFF, 0);
		queue_word(OP_CHECK, 5'd30, 32'h8000_0000, 8'h01, 8'h00, 0);
		queue_word(OP_CLEAR, '1, '1, '1, '1, 0);                 // clear with data held
		queue_word(OP_REMOVE, '0, '0, '0, '0, 0);                // nothing left after clear
		queue_word(OP_CLEAR, '0, '0, '0, '0, 0);                 // clear an empty ring
		queue_word(OP_CHECK, 5'd16, 32'h7FFF_FFFF, 8'h7F, 8'hFF, 0);
		queue_word(OP_CHECK, 5'd15, 32'hFFFF_FFFE, 8'h80, 8'h00, 0);
		queue_word(OP_REMOVE, '0, '0, '0, '0, 0);
		queue_word(OP_REMOVE, '0, '0, '0, '0, 0);
		queue_word(OP_CLEAR, '0, '0, '0, '0, 0);

		// random bursts: no gaps, heavy gaps, no gaps, light gaps
		queue_phase(0);
		queue_phase(57);
		queue_phase(0);
		queue_phase(14);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// wait for every word to be taken and every result to come back
		while (words_taken < words_planned || log_results_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);

		$display("covered %0d words: %0d logged, %0d dropped on full ring, %0d matches",
			words_taken, n_logged, n_dropped, n_matches);
		$display("  %0d records popped, %0d pops on empty ring, %0d clears, %0d unused codes",
			n_popped, n_empty_pops, n_clears, n_unused);
		if (mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#3_000_000;
		$display("timeout with %0d of %0d words taken", words_taken, words_planned);
		$display("simulation failed");
		$finish;
	end

endmodule

`default_nettype wire
